/* src/depth_grid_triangle_builder_macros.svh */
// Assertion macros for the depth grid triangle builder checker.
`ifndef DEPTH_GRID_TRIANGLE_BUILDER_MACROS_SVH
`define DEPTH_GRID_TRIANGLE_BUILDER_MACROS_SVH

// Check conseq in the cycle after cond, outside reset.
`define DGTB_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

// Check conseq in the same cycle as cond, outside reset.
`define DGTB_ASSERT_NOW(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Check conseq in the cycle after cond, reset included.
`define DGTB_ASSERT_ALWAYS_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) (cond) |=> (conseq)) else $error(msg);

`endif

/* src/dgtb_pkg.sv */
// ----------------------------------------------------------------------------
// dgtb_pkg
// Shared constants and types of the depth grid triangle builder.
// ----------------------------------------------------------------------------
package dgtb_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int DEPTH_BITS_DEF = 16;
  localparam int HEIGHT_LIMIT   = 2048;

  localparam int CFG_W     = 12;  // frame_width / frame_height register width
  localparam int THR_W     = 16;  // depth_threshold width
  localparam int YW        = 11;  // row counter width
  localparam int VTX_W     = 22;  // vertex index width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd1080;
  localparam logic [THR_W-1:0] THRESHOLD_RST    = 16'd50;

  // One grid cell whose corner produced at least one triangle.
  typedef struct packed {
    logic             ok_upper;  // triangle (tl, tr, bl)
    logic             ok_lower;  // triangle (tr, br, bl)
    logic [VTX_W-1:0] idx_tl;
    logic [CFG_W-1:0] width;
  } dgtb_cell_t;

endpackage

/* src/depth_grid_triangle_builder.sv */
// ----------------------------------------------------------------------------
// depth_grid_triangle_builder
// Builds grid triangles from a raster stream of per-pixel depths.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one depth per pixel in raster order, millimetres, 0 = invalid.
//   out_*  : one triangle per item, three linear vertex indices in tdata;
//            tlast marks the final triangle caused by a pixel. A pixel gives
//            zero, one or two triangles.
//   cfg_*  : register writes (0 frame width, 1 frame height, 2 depth
//            threshold); cfg_ready is always high. Write only while idle.
// Path: a triangle passes the intake register, the cell queue and the output
//   register, and waits in the queue while the output is not free.
// Throughput: one pixel per cycle while the cell queue is not full and pixels
//   give at most one triangle; a pixel giving two triangles holds the single
//   output register for both in turn, so the output channel sets the rate.
//   A four-entry cell queue absorbs short bursts and output stalls.
// Reset: counters, left and upper-left depths and registers return to their
//   defaults; the line store is not cleared, it is filled by the first row.
// Stall: while out_tready is low the result holds; once the queue fills, a pixel
//   that gives a triangle waits and in_tready drops until the output drains.
// ----------------------------------------------------------------------------
module depth_grid_triangle_builder
  import dgtb_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((DEPTH_BITS + 7) / 8) * 8-1:0] in_tdata,   // [DEPTH_BITS-1:0] depth_mm
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [71:0]                          out_tdata,  // vertex_a, vertex_b, vertex_c
  output logic                                 out_tlast,  // last_of_item
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [CFG_DATA_W-1:0]                cfg_data
);

  logic [CFG_W-1:0] frame_width_r, frame_height_r;
  logic [THR_W-1:0] threshold_r;
  logic [CFG_W:0]   w_clamp, h_clamp;
  logic [CFG_W-1:0] eff_width, eff_height;

  logic             q_push, q_pop, q_empty, q_full;
  dgtb_cell_t       push_cell, head;
  logic [VTX_W-1:0] vtx_a, vtx_b, vtx_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      threshold_r    <= THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:     frame_width_r  <= cfg_data[CFG_W-1:0];
        REG_FRAME_HEIGHT:    frame_height_r <= cfg_data[CFG_W-1:0];
        REG_DEPTH_THRESHOLD: threshold_r    <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the geometry to the supported range.
  always_comb begin
    priority if (frame_width_r < CFG_W'(2)) begin
      w_clamp = (CFG_W + 1)'(2);
    end else if ((CFG_W + 1)'(frame_width_r) > (CFG_W + 1)'(MAX_WIDTH)) begin
      w_clamp = (CFG_W + 1)'(MAX_WIDTH);
    end else begin
      w_clamp = (CFG_W + 1)'(frame_width_r);
    end
    priority if (frame_height_r < CFG_W'(2)) begin
      h_clamp = (CFG_W + 1)'(2);
    end else if ((CFG_W + 1)'(frame_height_r) > (CFG_W + 1)'(HEIGHT_LIMIT)) begin
      h_clamp = (CFG_W + 1)'(HEIGHT_LIMIT);
    end else begin
      h_clamp = (CFG_W + 1)'(frame_height_r);
    end
  end

  assign eff_width  = w_clamp[CFG_W-1:0];
  assign eff_height = h_clamp[CFG_W-1:0];

  dgtb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_depth   (in_tdata[DEPTH_BITS-1:0]),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .threshold  (threshold_r),
    .q_full     (q_full),
    .push       (q_push),
    .push_cell  (push_cell)
  );

  dgtb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cell (push_cell),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  dgtb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_a     (vtx_a),
    .out_b     (vtx_b),
    .out_c     (vtx_c),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'b0, vtx_c, vtx_b, vtx_a};

endmodule

/* src/dgtb_front.sv */
// ----------------------------------------------------------------------------
// dgtb_front
// Pixel intake: counters, previous-row line store, triangle tests per cell.
// ----------------------------------------------------------------------------
module dgtb_front
  import dgtb_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DEPTH_BITS-1:0] in_depth,
  input  logic [CFG_W-1:0]      eff_width,
  input  logic [CFG_W-1:0]      eff_height,
  input  logic [THR_W-1:0]      threshold,
  input  logic                  q_full,
  output logic                  push,
  output dgtb_cell_t            push_cell
);

  localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = (DEPTH_BITS > THR_W) ? DEPTH_BITS : THR_W;
  localparam int PW = YW + CFG_W;

  logic [DEPTH_BITS-1:0] row_mem [MAX_WIDTH];

  logic [XW-1:0]         x_r, x_nxt;
  logic [YW-1:0]         y_r, y_nxt;
  logic                  s1_v_r, s1_v_nxt;
  logic [DEPTH_BITS-1:0] s1_d_r;
  logic [XW-1:0]         s1_x_r;
  logic [YW-1:0]         s1_y_r;
  logic [CFG_W-1:0]      s1_w_r;
  logic [DEPTH_BITS-1:0] above_r;
  logic [DEPTH_BITS-1:0] left_r;
  logic [DEPTH_BITS-1:0] ul_r;

  logic          acc;
  logic [XW-1:0] xe;
  logic [YW-1:0] ye;
  logic          corner, ok_upper, ok_lower, any_tri, s1_adv;
  logic [XW-1:0] xm1;
  logic [YW-1:0] ym1;
  logic [PW-1:0] prod;

  function automatic logic tri_ok(input logic [DEPTH_BITS-1:0] d1,
                                  input logic [DEPTH_BITS-1:0] d2,
                                  input logic [DEPTH_BITS-1:0] d3,
                                  input logic [THR_W-1:0]      thr);
    logic [DEPTH_BITS-1:0] a12, a13, a23;
    a12 = (d1 > d2) ? d1 - d2 : d2 - d1;
    a13 = (d1 > d3) ? d1 - d3 : d3 - d1;
    a23 = (d2 > d3) ? d2 - d3 : d3 - d2;
    return (d1 != '0) && (d2 != '0) && (d3 != '0) &&
           (CW'(a12) <= CW'(thr)) && (CW'(a13) <= CW'(thr)) && (CW'(a23) <= CW'(thr));
  endfunction

  assign acc = in_valid && in_ready;

  // Restart a counter at zero if a register change left it out of range.
  assign xe = (CFG_W'(x_r) >= eff_width)  ? '0 : x_r;
  assign ye = (CFG_W'(y_r) >= eff_height) ? '0 : y_r;

  always_comb begin
    x_nxt = xe + 1'b1;
    y_nxt = ye;
    if ((CFG_W + 1)'(xe) + 1'b1 >= (CFG_W + 1)'(eff_width)) begin
      x_nxt = '0;
      if ((CFG_W + 1)'(ye) + 1'b1 >= (CFG_W + 1)'(eff_height)) begin
        y_nxt = '0;
      end else begin
        y_nxt = ye + 1'b1;
      end
    end
  end

  // Read-first line store: the old entry is the pixel above.
  always_ff @(posedge clk) begin
    if (acc) begin
      above_r     <= row_mem[xe];
      row_mem[xe] <= in_depth;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_d_r <= in_depth;
      s1_x_r <= xe;
      s1_y_r <= ye;
      s1_w_r <= eff_width;
    end
  end

  assign corner   = (s1_x_r != '0) && (s1_y_r != '0);
  assign ok_upper = corner && tri_ok(ul_r, above_r, left_r, threshold);
  assign ok_lower = corner && tri_ok(above_r, s1_d_r, left_r, threshold);
  assign any_tri  = ok_upper || ok_lower;
  assign s1_adv   = s1_v_r && (!any_tri || !q_full);
  assign push     = s1_v_r && any_tri && !q_full;
  assign in_ready = !s1_v_r || s1_adv;

  assign xm1  = s1_x_r - 1'b1;
  assign ym1  = s1_y_r - 1'b1;
  assign prod = PW'(ym1) * PW'(s1_w_r);

  always_comb begin
    push_cell.ok_upper = ok_upper;
    push_cell.ok_lower = ok_lower;
    push_cell.idx_tl   = VTX_W'(prod + PW'(xm1));
    push_cell.width    = s1_w_r;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      s1_v_r <= 1'b0;
      left_r <= '0;
      ul_r   <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (acc) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
      end
      if (s1_adv) begin
        ul_r   <= above_r;
        left_r <= s1_d_r;
      end
    end
  end

endmodule

/* src/dgtb_queue.sv */
// ----------------------------------------------------------------------------
// dgtb_queue
// Short FIFO of grid cells between the pixel intake and the triangle emitter.
// ----------------------------------------------------------------------------
module dgtb_queue
  import dgtb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  dgtb_cell_t push_cell,
  input  logic       pop,
  output dgtb_cell_t head,
  output logic       empty,
  output logic       full
);

  dgtb_cell_t          slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_r, rd_r;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign head  = slots_r[rd_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

endmodule

/* src/dgtb_back.sv */
// ----------------------------------------------------------------------------
// dgtb_back
// Triangle emitter: turns each queued cell into one or two output triangles.
// ----------------------------------------------------------------------------
module dgtb_back
  import dgtb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dgtb_cell_t       head,
  input  logic             q_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VTX_W-1:0] out_a,
  output logic [VTX_W-1:0] out_b,
  output logic [VTX_W-1:0] out_c,
  output logic             out_last
);

  logic             phase_r;      // upper triangle of the head cell already sent
  logic             out_valid_r;
  logic [VTX_W-1:0] a_r, b_r, c_r;
  logic             last_r;

  logic             load, first;
  logic [VTX_W-1:0] idx_tr, idx_bl, idx_br;

  assign load   = !q_empty && (!out_valid_r || out_ready);
  assign first  = !phase_r && head.ok_upper;
  assign pop    = load && !(first && head.ok_lower);
  assign idx_tr = head.idx_tl + 1'b1;
  assign idx_bl = head.idx_tl + VTX_W'(head.width);
  assign idx_br = idx_bl + 1'b1;

  always_ff @(posedge clk) begin
    if (load) begin
      a_r    <= first ? head.idx_tl : idx_tr;
      b_r    <= first ? idx_tr : idx_br;
      c_r    <= idx_bl;
      last_r <= first ? !head.ok_lower : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        phase_r     <= first && head.ok_lower;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_a     = a_r;
  assign out_b     = b_r;
  assign out_c     = c_r;
  assign out_last  = last_r;

endmodule

/* src/dgtb_checker.sv */
// ----------------------------------------------------------------------------
// dgtb_checker
// Port-level checks of the depth grid triangle builder, bound to the top.
// ----------------------------------------------------------------------------
`include "depth_grid_triangle_builder_macros.svh"

module dgtb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast
);

  // A stalled triangle holds.
  `DGTB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled triangle changed")

  // Nothing comes out right after reset.
  `DGTB_ASSERT_ALWAYS_NEXT(a_rst_quiet, !rst_n, !out_tvalid, "output valid after reset")

  // Every triangle is either the upper or the lower one of a cell.
  `DGTB_ASSERT_NOW(a_tri_shape, out_tvalid, (out_tdata[43:22] == out_tdata[21:0] + 22'd1) || (out_tdata[65:44] == out_tdata[43:22] - 22'd1), "triangle indices do not form a cell half")

  // The lower triangle follows the upper one at once, starting one column on.
  `DGTB_ASSERT_NEXT(a_pair_follow, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tlast && (out_tdata[21:0] == $past(out_tdata[21:0]) + 22'd1), "second triangle of a cell missing")

endmodule

bind depth_grid_triangle_builder dgtb_checker u_dgtb_checker (.*);

/* test/depth_grid_triangle_builder_test.sv */
// ----------------------------------------------------------------------------
// depth_grid_triangle_builder_test
// Stream-level check of the depth grid triangle builder. Depth frames of many
// sizes and thresholds go in through the pixel channel; an independent
// predictor keeps its own line store, neighbor depths and counters, works out
// the triangles each pixel must give, and every triangle that comes out is
// matched in order against it. Register writes happen only while the block
// is idle, and both stream sides run with and without random gaps.
// ----------------------------------------------------------------------------
module depth_grid_triangle_builder_test;
  import dgtb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNASSIGNED = 2'd3;
  localparam int DEPTH_W = DEPTH_BITS_DEF;

  typedef enum int unsigned {
    PACE_STEADY,
    PACE_SENDER_GAPS,
    PACE_RECEIVER_STALLS,
    PACE_BOTH
  } pace_t;

  typedef struct packed {
    logic [VTX_W-1:0] va;
    logic [VTX_W-1:0] vb;
    logic [VTX_W-1:0] vc;
    logic             last;
  } tri_t;

  typedef struct {
    bit                    set_w;
    bit                    set_h;
    bit                    set_t;
    bit                    poke_spare;
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    logic [CFG_DATA_W-1:0] t;
    logic [CFG_DATA_W-1:0] spare;
  } settings_t;

  // --------------------------------------------------------------------------
  // Triangle predictor and checker
  // --------------------------------------------------------------------------
  class triangle_scoreboard;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [DEPTH_W-1:0] prev_row [MAX_WIDTH_DEF];
    bit                 filled [MAX_WIDTH_DEF];
    logic [DEPTH_W-1:0] left_d;
    logic [DEPTH_W-1:0] upleft_d;
    int unsigned        col;
    int unsigned        row;
    tri_t               expected_tris[$];
    int unsigned        failures;
    int unsigned        pixels;
    int unsigned        triangles;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      thr_reg    = THRESHOLD_RST;
      foreach (filled[i]) begin
        filled[i]   = 1'b0;
        prev_row[i] = '0;
      end
      left_d    = '0;
      upleft_d  = '0;
      col       = 0;
      row       = 0;
      failures  = 0;
      pixels    = 0;
      triangles = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned cols();
      return clamp_dim(width_reg, MAX_WIDTH_DEF);
    endfunction

    function int unsigned rows();
      return clamp_dim(height_reg, HEIGHT_LIMIT);
    endfunction

    function void report_failure(string what);
      failures++;
      if (failures <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:     width_reg  = data[CFG_W-1:0];
        REG_FRAME_HEIGHT:    height_reg = data[CFG_W-1:0];
        REG_DEPTH_THRESHOLD: thr_reg    = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function bit depths_agree(logic [DEPTH_W-1:0] d1, logic [DEPTH_W-1:0] d2,
                              logic [DEPTH_W-1:0] d3);
      int unsigned a, b, c;
      a = d1;
      b = d2;
      c = d3;
      if (a == 0 || b == 0 || c == 0) return 1'b0;
      if ((a > b ? a - b : b - a) > thr_reg) return 1'b0;
      if ((a > c ? a - c : c - a) > thr_reg) return 1'b0;
      if ((b > c ? b - c : c - b) > thr_reg) return 1'b0;
      return 1'b1;
    endfunction

    function void push_tri(int unsigned a, int unsigned b, int unsigned c, bit last);
      tri_t t;
      t.va   = a[VTX_W-1:0];
      t.vb   = b[VTX_W-1:0];
      t.vc   = c[VTX_W-1:0];
      t.last = last;
      expected_tris.push_back(t);
    endfunction

    function void note_pixel(logic [DEPTH_W-1:0] depth);
      int unsigned        w, h, x, y, itl;
      logic [DEPTH_W-1:0] above;
      bit                 upper_ok, lower_ok;
      w = cols();
      h = rows();
      x = col;
      y = row;
      // counters left beyond a shrunk frame restart at zero
      if (x >= w) x = 0;
      if (y >= h) y = 0;
      above = prev_row[x];
      if (x > 0 && y > 0) begin
        itl      = (x - 1) + (y - 1) * w;
        upper_ok = depths_agree(upleft_d, above, left_d);
        lower_ok = depths_agree(above, depth, left_d);
        if (upper_ok) push_tri(itl, itl + 1, itl + w, !lower_ok);
        if (lower_ok) push_tri(itl + 1, itl + w + 1, itl + w, 1'b1);
      end
      upleft_d    = above;
      prev_row[x] = depth;
      filled[x]   = 1'b1;
      left_d      = depth;
      x++;
      if (x >= w) begin
        x = 0;
        y++;
        if (y >= h) y = 0;
      end
      col = x;
      row = y;
      pixels++;
    endfunction

    function void check_triangle(logic [71:0] data, logic last);
      tri_t got, want;
      got.va   = data[VTX_W-1:0];
      got.vb   = data[2*VTX_W-1:VTX_W];
      got.vc   = data[3*VTX_W-1:2*VTX_W];
      got.last = last;
      if (expected_tris.size() == 0) begin
        report_failure($sformatf("unexpected triangle a=%0d b=%0d c=%0d last=%0b",
                                 got.va, got.vb, got.vc, got.last));
        return;
      end
      want = expected_tris.pop_front();
      if (got !== want || data[71:3*VTX_W] !== '0)
        report_failure($sformatf(
          "expected a=%0d b=%0d c=%0d last=%0b, got a=%0d b=%0d c=%0d last=%0b pad=%h",
          want.va, want.vb, want.vc, want.last,
          got.va, got.vb, got.vc, got.last, data[71:3*VTX_W]));
      triangles++;
    endfunction

    // Pixels still to go before the counters are back at the frame origin.
    function int unsigned to_frame_start();
      int unsigned w, h, x, y;
      w = cols();
      h = rows();
      x = (col >= w) ? 0 : col;
      y = (row >= h) ? 0 : row;
      if (x == 0 && y == 0) return 0;
      return (h - y) * w - x;
    endfunction

    // True when the new frame size would read line store columns never filled.
    function bit needs_refill(logic [CFG_W-1:0] new_w, logic [CFG_W-1:0] new_h);
      int unsigned w, h;
      w = clamp_dim(new_w, MAX_WIDTH_DEF);
      h = clamp_dim(new_h, HEIGHT_LIMIT);
      if (row >= h || row == 0) return 1'b0;
      for (int c = 0; c < w; c++)
        if (!filled[c]) return 1'b1;
      return 1'b0;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and clocking
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // [15:0] depth_mm
  logic                  out_tvalid;
  logic                  out_tready;
  logic [71:0]           out_tdata;  // [21:0] vertex_a, [43:22] vertex_b, [65:44] vertex_c
  logic                  out_tlast;  // last_of_item
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  depth_grid_triangle_builder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  triangle_scoreboard sb = new();

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned depth_base;
  int unsigned depth_span;
  int unsigned phase_count;
  int unsigned refill_pixels;

  logic [15:0] corner_pixels [18] = '{
    16'd500,   16'd550,   16'd600,
    16'd520,   16'd560,   16'd0,
    16'd65535, 16'd600,   16'd1,
    16'd65535, 16'd65535, 16'd65485,
    16'd0,     16'd100,   16'd100,
    16'd100,   16'd100,   16'd100
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_pixel(in_tdata[DEPTH_W-1:0]);
      if (out_tvalid && out_tready) sb.check_triangle(out_tdata, out_tlast);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic logic [15:0] next_depth();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return 16'd0;
    if (pick < 9) return 16'hFFFF;
    if (pick < 16) return 16'($urandom_range(0, 65535));
    return 16'(depth_base + $urandom_range(0, depth_span));
  endfunction

  function automatic settings_t fixed_settings(logic [15:0] w, logic [15:0] h,
                                               logic [15:0] t, bit poke);
    settings_t s;
    s.set_w      = 1'b1;
    s.set_h      = 1'b1;
    s.set_t      = 1'b1;
    s.poke_spare = poke;
    s.w          = w;
    s.h          = h;
    s.t          = t;
    s.spare      = 16'($urandom_range(0, 65535));
    return s;
  endfunction

  function automatic settings_t random_settings();
    settings_t   s;
    int unsigned pick;
    s.set_w      = ($urandom_range(0, 9) < 7);
    s.set_h      = ($urandom_range(0, 9) < 7);
    s.set_t      = ($urandom_range(0, 9) < 7);
    s.poke_spare = ($urandom_range(0, 6) == 0);
    if (!s.set_w && !s.set_h) s.set_t = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 60)      s.w = 16'($urandom_range(2, 16));
    else if (pick < 85) s.w = 16'($urandom_range(17, 64));
    else if (pick < 95) s.w = 16'($urandom_range(65, 300));
    else                s.w = 16'($urandom_range(0, 1));
    s.w[15:12] = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 70)      s.h = 16'($urandom_range(2, 8));
    else if (pick < 90) s.h = 16'($urandom_range(9, 40));
    else if (pick < 95) s.h = 16'($urandom_range(0, 1));
    else                s.h = 16'h0FFF;
    s.h[15:12] = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 20)      s.t = 16'd0;
    else if (pick < 60) s.t = 16'($urandom_range(1, 100));
    else if (pick < 85) s.t = 16'($urandom_range(101, 3000));
    else if (pick < 93) s.t = 16'hFFFF;
    else                s.t = 16'($urandom_range(0, 65535));
    s.spare = 16'($urandom_range(0, 65535));
    return s;
  endfunction

  task automatic send_pixel(input logic [15:0] depth);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= depth;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Wait for every predicted triangle, then let the pipeline settle.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    while (sb.expected_tris.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_settings(input settings_t s);
    logic [CFG_W-1:0]      nw, nh;
    int unsigned           n;
    logic [CFG_IDX_W-1:0]  idx_q[$];
    logic [CFG_DATA_W-1:0] data_q[$];
    nw = s.set_w ? s.w[CFG_W-1:0] : sb.width_reg;
    nh = s.set_h ? s.h[CFG_W-1:0] : sb.height_reg;
    // finish the frame first so the widened line store is refilled by row 0
    if (sb.needs_refill(nw, nh)) begin
      n = sb.to_frame_start();
      refill_pixels += n;
      repeat (n) send_pixel(next_depth());
      in_tvalid <= 1'b0;
      drain();
    end
    if (s.set_w) begin
      idx_q.push_back(REG_FRAME_WIDTH);
      data_q.push_back(s.w);
    end
    if (s.set_h) begin
      idx_q.push_back(REG_FRAME_HEIGHT);
      data_q.push_back(s.h);
    end
    if (s.set_t) begin
      idx_q.push_back(REG_DEPTH_THRESHOLD);
      data_q.push_back(s.t);
    end
    if (s.poke_spare) begin
      idx_q.push_back(REG_UNASSIGNED);
      data_q.push_back(s.spare);
    end
    foreach (idx_q[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_q[i];
      cfg_data  <= data_q[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input settings_t s, input int unsigned count,
                           input bit directed);
    pace_t       pace;
    int unsigned thr;
    pace = pace_t'(phase_count % 4);
    case (pace)
      PACE_STEADY: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      PACE_SENDER_GAPS: begin
        idle_pct  = 52;
        stall_pct = 0;
      end
      PACE_RECEIVER_STALLS: begin
        idle_pct  = 0;
        stall_pct = 52;
      end
      default: begin
        idle_pct  = 36;
        stall_pct = 36;
      end
    endcase
    apply_settings(s);
    // keep most depths within reach of the threshold so triangles show up
    thr = sb.thr_reg;
    depth_span = (thr == 0) ? 1 : ((thr > 3000) ? 4000 : thr * 3 / 2 + 1);
    depth_base = $urandom_range(1, 65535 - depth_span);
    if (directed)
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    else
      repeat (count) send_pixel(next_depth());
    in_tvalid <= 1'b0;
    drain();
    phase_count++;
  endtask

  initial begin
    int unsigned random_total;
    int unsigned n;
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    out_tready    <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_FRAME_WIDTH;
    cfg_data      <= '0;
    idle_pct      = 0;
    stall_pct     = 0;
    depth_base    = 1000;
    depth_span    = 50;
    phase_count   = 0;
    refill_pixels = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small frame: both triangles, one of each, invalid pixels, frame wrap
    run_phase(fixed_settings(16'd3, 16'd4, 16'd50, 1'b0), 0, 1'b1);
    run_phase(fixed_settings(16'd2, 16'd2, 16'd0, 1'b0), 120, 1'b0);
    run_phase(fixed_settings(16'h0000, 16'h0001, 16'hFFFF, 1'b0), 120, 1'b0);
    run_phase(fixed_settings(16'hF005, 16'hFFFF, 16'd100, 1'b1), 200, 1'b0);
    // wide frame: a whole frame of two long rows through the line store
    run_phase(fixed_settings(16'h0200, 16'h3002, 16'($urandom_range(0, 400)), 1'b0),
              1024, 1'b0);
    // a width beyond the line store clamps to its size
    run_phase(fixed_settings(16'h7FFF, 16'd2, 16'd30, 1'b0), 100, 1'b0);
    random_total = 1582;
    while (random_total < 1950) begin
      n = $urandom_range(90, 200);
      run_phase(random_settings(), n, 1'b0);
      random_total += n;
    end

    if (sb.expected_tris.size() != 0)
      sb.report_failure($sformatf("%0d triangles never arrived", sb.expected_tris.size()));
    $display("Ran %0d pixels (%0d to finish frames) over %0d register settings.",
             sb.pixels, refill_pixels, phase_count);
    $display("Matched %0d triangles; %0d failures.", sb.triangles, sb.failures);
    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
